// File: rtl/core/soft_sphere_energy_check_macros.svh
// Assertion macros shared by the soft-sphere energy check RTL
`ifndef SOFT_SPHERE_ENERGY_CHECK_MACROS_SVH
`define SOFT_SPHERE_ENERGY_CHECK_MACROS_SVH

// Condition that holds at every clock edge out of reset
`define SSE_CHK(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define SSE_CHK_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SSE_CHK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sse_pkg.sv
// Shared types and constants for the soft-sphere energy check
package sse_pkg;

    localparam int unsigned MAX_PARTICLES_DEF = 256;
    localparam int unsigned DATA_W            = 32;
    localparam int unsigned ENERGY_W          = 48;
    localparam int unsigned CFG_IDX_W         = 2;

    localparam logic [DATA_W-1:0] BOX_LENGTH_RST    = 32'h0001_0000;
    localparam logic [DATA_W-1:0] SIZE_SCALE_RST    = 32'h0001_0000;
    localparam logic [DATA_W-1:0] PAIR_STRENGTH_RST = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_LENGTH    = 2'd0,
        CFG_SIZE_SCALE    = 2'd1,
        CFG_PAIR_STRENGTH = 2'd2
    } t_cfg_idx;

    // Operand selection of the shared multiplier
    typedef enum logic [3:0] {
        MUL_VX,
        MUL_VY,
        MUL_VZ,
        MUL_MX,
        MUL_MY,
        MUL_MZ,
        MUL_DS,
        MUL_FF,
        MUL_ST
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     acc_clr;
        logic     acc_add;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     spd_upd;
        logic     k_clr;
        logic     k_inc;
        logic     mem_rd;
        logic     axis_ld;
        logic     d_ld;
        logic     sqrt_step;
        logic     div_init;
        logic     div_step;
        logic     ovl_add;
        logic     store;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic no_pairs;
        logic pair_last;
        logic d_lt;
        logic out_full;
    } t_sts;

endpackage

// File: rtl/core/sse_if.sv
// Valid/ready channel interfaces for particle input and energy results
interface sse_in_if;
    logic                               valid;
    logic                               ready;
    logic        [sse_pkg::DATA_W-1:0]  pos_x;
    logic        [sse_pkg::DATA_W-1:0]  pos_y;
    logic        [sse_pkg::DATA_W-1:0]  pos_z;
    logic signed [sse_pkg::DATA_W-1:0]  vel_x;
    logic signed [sse_pkg::DATA_W-1:0]  vel_y;
    logic signed [sse_pkg::DATA_W-1:0]  vel_z;
    logic        [sse_pkg::DATA_W-1:0]  diameter;
    logic                               last_particle;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, diameter,
                    last_particle, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, diameter,
                    last_particle, output ready);
endinterface

interface sse_out_if;
    logic                           valid;
    logic                           ready;
    logic [sse_pkg::ENERGY_W-1:0]   kinetic_energy;
    logic [sse_pkg::ENERGY_W-1:0]   potential_energy;
    logic [sse_pkg::ENERGY_W-1:0]   total_energy;

    modport source (output valid, kinetic_energy, potential_energy, total_energy,
                    input ready);
    modport sink   (input valid, kinetic_energy, potential_energy, total_energy,
                    output ready);
endinterface

// File: rtl/core/sse_ctrl.sv
// Sequencer for the soft-sphere energy check
`include "soft_sphere_energy_check_macros.svh"

module sse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sse_pkg::t_sts i_sts,
    output sse_pkg::t_cmd o_cmd
);

    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned DIV_STEPS  = 30;

    typedef enum logic [4:0] {
        ST_IDLE, ST_V0, ST_V1, ST_V2, ST_VACC, ST_SPD,
        ST_RD, ST_AX, ST_S0, ST_S1, ST_S2, ST_S3, ST_DLD,
        ST_SQRT, ST_CMP, ST_DIV, ST_FSQ, ST_FST, ST_PADD, ST_NEXT, ST_STORE
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.mul_sel = sse_pkg::MUL_VX;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_V0;
                end
            end
            ST_V0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = sse_pkg::MUL_VX;
                o_cmd.acc_clr = 1'b1;
                n_state = ST_V1;
            end
            ST_V1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = sse_pkg::MUL_VY;
                o_cmd.acc_add = 1'b1;
                n_state = ST_V2;
            end
            ST_V2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = sse_pkg::MUL_VZ;
                o_cmd.acc_add = 1'b1;
                n_state = ST_VACC;
            end
            ST_VACC: begin
                o_cmd.acc_add = 1'b1;
                n_state = ST_SPD;
            end
            ST_SPD: begin
                o_cmd.spd_upd = 1'b1;
                o_cmd.k_clr   = 1'b1;
                n_state = i_sts.no_pairs ? ST_STORE : ST_RD;
            end
            ST_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = ST_AX;
            end
            ST_AX: begin
                o_cmd.axis_ld = 1'b1;
                n_state = ST_S0;
            end
            ST_S0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = sse_pkg::MUL_MX;
                o_cmd.acc_clr = 1'b1;
                n_state = ST_S1;
            end
            ST_S1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = sse_pkg::MUL_MY;
                o_cmd.acc_add = 1'b1;
                n_state = ST_S2;
            end
            ST_S2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = sse_pkg::MUL_MZ;
                o_cmd.acc_add = 1'b1;
                n_state = ST_S3;
            end
            ST_S3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = sse_pkg::MUL_DS;
                o_cmd.acc_add = 1'b1;
                n_state = ST_DLD;
            end
            ST_DLD: begin
                o_cmd.d_ld = 1'b1;
                n_cnt   = 5'(SQRT_STEPS - 1);
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_sts.d_lt) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt   = 5'(DIV_STEPS - 1);
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = ST_FSQ;
                end
            end
            ST_FSQ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = sse_pkg::MUL_FF;
                n_state = ST_FST;
            end
            ST_FST: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = sse_pkg::MUL_ST;
                n_state = ST_PADD;
            end
            ST_PADD: begin
                o_cmd.ovl_add = 1'b1;
                n_state = ST_NEXT;
            end
            ST_NEXT: begin
                if (i_sts.pair_last) begin
                    n_state = ST_STORE;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_STORE: begin
                // on the last particle, hold while the previous result still waits
                if (!(i_sts.last && i_sts.out_full)) begin
                    o_cmd.store = 1'b1;
                    o_cmd.emit  = i_sts.last;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `SSE_CHK_IMPL(a_emit_when_free, o_cmd.emit, i_sts.last && !i_sts.out_full, "emit blocked")
    `SSE_CHK_NEXT(a_accept_leaves_idle, i_in_valid && o_in_ready, r_state == ST_V0, "no start")

endmodule

// File: rtl/core/sse_dp.sv
// Datapath: particle store, shared multiplier, square root and divider, energy sums
`include "soft_sphere_energy_check_macros.svh"

module sse_dp #(
    parameter int unsigned MAX_PARTICLES = sse_pkg::MAX_PARTICLES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic        [sse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [sse_pkg::DATA_W-1:0]     i_cfg_wdata,
    input  logic        [sse_pkg::DATA_W-1:0]     i_pos_x,
    input  logic        [sse_pkg::DATA_W-1:0]     i_pos_y,
    input  logic        [sse_pkg::DATA_W-1:0]     i_pos_z,
    input  logic signed [sse_pkg::DATA_W-1:0]     i_vel_x,
    input  logic signed [sse_pkg::DATA_W-1:0]     i_vel_y,
    input  logic signed [sse_pkg::DATA_W-1:0]     i_vel_z,
    input  logic        [sse_pkg::DATA_W-1:0]     i_diameter,
    input  logic                                  i_last_particle,
    input  sse_pkg::t_cmd                         i_cmd,
    output sse_pkg::t_sts                         o_sts,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic        [sse_pkg::ENERGY_W-1:0]   o_kinetic,
    output logic        [sse_pkg::ENERGY_W-1:0]   o_potential,
    output logic        [sse_pkg::ENERGY_W-1:0]   o_total
);

    localparam int unsigned CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam int unsigned ADR_W = $clog2(MAX_PARTICLES);
    localparam int unsigned EW    = sse_pkg::ENERGY_W;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [30:0] axis_dist(input logic [31:0] p, input logic [31:0] q,
                                              input logic [31:0] l);
        logic [31:0] a;
        logic [31:0] w;
        logic [31:0] m;
        a = (p > q) ? (p - q) : (q - p);
        if (a <= l) begin
            w = l - a;
            m = (w < a) ? w : a;
        end else begin
            m = a - l;
        end
        axis_dist = (m > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : m[30:0];
    endfunction

    function automatic logic [EW-1:0] sat_add(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic [EW:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[EW] ? '1 : s[EW-1:0];
    endfunction

    // configuration
    logic [31:0] r_box, r_scale, r_strength;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box      <= sse_pkg::BOX_LENGTH_RST;
            r_scale    <= sse_pkg::SIZE_SCALE_RST;
            r_strength <= sse_pkg::PAIR_STRENGTH_RST;
        end else if (i_cfg_wr_en) begin
            case (sse_pkg::t_cfg_idx'(i_cfg_index))
                sse_pkg::CFG_BOX_LENGTH:    r_box      <= i_cfg_wdata;
                sse_pkg::CFG_SIZE_SCALE:    r_scale    <= i_cfg_wdata;
                sse_pkg::CFG_PAIR_STRENGTH: r_strength <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // current particle
    logic [31:0] r_px, r_py, r_pz, r_dia, r_vmx, r_vmy, r_vmz;
    logic        r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_pz   <= i_pos_z;
            r_dia  <= i_diameter;
            r_vmx  <= mag32(i_vel_x);
            r_vmy  <= mag32(i_vel_y);
            r_vmz  <= mag32(i_vel_z);
            r_last <= i_last_particle;
        end
    end

    // particle store and pair index
    logic [127:0]     r_mem [MAX_PARTICLES];
    logic [127:0]     r_rd;
    logic [CNT_W-1:0] r_count, r_k;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && (r_count < CNT_W'(MAX_PARTICLES))) begin
            r_mem[r_count[ADR_W-1:0]] <= {r_px, r_py, r_pz, r_dia};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[r_k[ADR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_k     <= '0;
        end else begin
            if (i_cmd.emit) begin
                r_count <= '0;
            end else if (i_cmd.store && (r_count < CNT_W'(MAX_PARTICLES))) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    logic [31:0] rd_dia;
    logic [32:0] dsum;
    assign rd_dia = r_rd[31:0];
    assign dsum   = {1'b0, rd_dia} + {1'b0, r_dia};

    // per-axis minimum-image distances
    logic [30:0] r_mx, r_my, r_mz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.axis_ld) begin
            r_mx <= axis_dist(r_rd[127:96], r_px, r_box);
            r_my <= axis_dist(r_rd[95:64], r_py, r_box);
            r_mz <= axis_dist(r_rd[63:32], r_pz, r_box);
        end
    end

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] r_prod, r_acc;
    logic [29:0] r_q;
    logic        r_dz;
    logic [30:0] frac;

    assign frac = r_dz ? 31'h4000_0000 : {1'b0, r_q};

    always_comb begin
        case (i_cmd.mul_sel)
            sse_pkg::MUL_VX: begin mul_a = r_vmx; mul_b = r_vmx; end
            sse_pkg::MUL_VY: begin mul_a = r_vmy; mul_b = r_vmy; end
            sse_pkg::MUL_VZ: begin mul_a = r_vmz; mul_b = r_vmz; end
            sse_pkg::MUL_MX: begin mul_a = {1'b0, r_mx}; mul_b = {1'b0, r_mx}; end
            sse_pkg::MUL_MY: begin mul_a = {1'b0, r_my}; mul_b = {1'b0, r_my}; end
            sse_pkg::MUL_MZ: begin mul_a = {1'b0, r_mz}; mul_b = {1'b0, r_mz}; end
            sse_pkg::MUL_DS: begin mul_a = r_scale; mul_b = dsum[31:0]; end
            sse_pkg::MUL_FF: begin mul_a = {1'b0, frac}; mul_b = {1'b0, frac}; end
            sse_pkg::MUL_ST: begin mul_a = r_strength; mul_b = r_prod[61:30]; end
            default:         begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // pair size D and integer square root of the squared distance
    logic [47:0] r_dsz;
    logic [63:0] r_op, r_res, r_one;
    logic [63:0] trial;
    logic [31:0] root_d;

    assign trial  = r_res + r_one;
    assign root_d = r_res[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.d_ld) begin
            r_dsz <= 48'(r_prod[63:17]) + (dsum[32] ? {1'b0, r_scale, 15'b0} : 48'd0);
            r_op  <= r_acc;
            r_res <= '0;
            r_one <= 64'h4000_0000_0000_0000;
        end else if (i_cmd.sqrt_step) begin
            if (r_op >= trial) begin
                r_op  <= r_op - trial;
                r_res <= (r_res >> 1) + r_one;
            end else begin
                r_res <= r_res >> 1;
            end
            r_one <= r_one >> 2;
        end
    end

    // restoring division (D - d) / D, one quotient bit a cycle
    logic [47:0] r_rem;
    logic [48:0] rem_sh;

    assign rem_sh = {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= r_dsz - {16'b0, root_d};
            r_q   <= '0;
            r_dz  <= (root_d == '0);
        end else if (i_cmd.div_step) begin
            if (rem_sh >= {1'b0, r_dsz}) begin
                r_rem <= 48'(rem_sh - {1'b0, r_dsz});
                r_q   <= {r_q[28:0], 1'b1};
            end else begin
                r_rem <= rem_sh[47:0];
                r_q   <= {r_q[28:0], 1'b0};
            end
        end
    end

    // energy sums
    logic [EW-1:0] r_spd, r_ovl;
    logic [55:0]   spd_sum;
    logic [EW-1:0] spd_next;

    assign spd_sum  = {8'b0, r_spd} + {1'b0, r_acc[63:9]};
    assign spd_next = (spd_sum[55:EW] != '0) ? '1 : spd_sum[EW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd <= '0;
            r_ovl <= '0;
        end else if (i_cmd.emit) begin
            r_spd <= '0;
            r_ovl <= '0;
        end else begin
            if (i_cmd.spd_upd) begin
                r_spd <= spd_next;
            end
            if (i_cmd.ovl_add) begin
                r_ovl <= sat_add(r_ovl, {7'b0, r_prod[63:23]});
            end
        end
    end

    // result register
    logic          r_o_valid;
    logic [EW-1:0] r_o_kin, r_o_pot, r_o_tot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_kin <= r_spd;
            r_o_pot <= r_ovl;
            r_o_tot <= sat_add(r_spd, r_ovl);
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_kinetic   = r_o_kin;
    assign o_potential = r_o_pot;
    assign o_total     = r_o_tot;

    assign o_sts.last      = r_last;
    assign o_sts.no_pairs  = (r_count == '0);
    assign o_sts.pair_last = (CNT_W'(r_k + 1'b1) >= r_count);
    assign o_sts.d_lt      = ({16'b0, root_d} < r_dsz);
    assign o_sts.out_full  = r_o_valid && !i_out_ready;

    `SSE_CHK(a_count_bound, r_count <= CNT_W'(MAX_PARTICLES), "particle count past depth")
    `SSE_CHK_IMPL(a_read_stored, i_cmd.mem_rd, r_k < r_count, "read of unstored entry")
    `SSE_CHK_NEXT(a_result_order, i_cmd.emit, r_o_valid && (r_o_tot >= r_o_kin) && (r_o_tot >= r_o_pot), "bad result")

endmodule

// File: rtl/core/soft_sphere_energy_check.sv
// Sequencing: an item sums its squared speed, then runs the pair loop over the stored
// particles; the result register is loaded in the item's last cycle.
// Throughput: one item at a time; the pair loop runs the 32-step square root and,
// for overlapping pairs, the 30-step divider on one shared 32x32 multiplier.
// Reset: synchronous active low; clears counts and sums, loads config defaults.
// Top level of the soft-sphere energy check
module soft_sphere_energy_check #(
    parameter int unsigned MAX_PARTICLES = sse_pkg::MAX_PARTICLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [sse_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sse_pkg::DATA_W-1:0]        i_cfg_wdata,
    sse_in_if.sink                            i_in,
    sse_out_if.source                         o_out
);

    sse_pkg::t_cmd cmd;
    sse_pkg::t_sts sts;
    logic          in_ready;

    assign i_in.ready = in_ready;

    sse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sse_dp #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_pos_x         (i_in.pos_x),
        .i_pos_y         (i_in.pos_y),
        .i_pos_z         (i_in.pos_z),
        .i_vel_x         (i_in.vel_x),
        .i_vel_y         (i_in.vel_y),
        .i_vel_z         (i_in.vel_z),
        .i_diameter      (i_in.diameter),
        .i_last_particle (i_in.last_particle),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_kinetic       (o_out.kinetic_energy),
        .o_potential     (o_out.potential_energy),
        .o_total         (o_out.total_energy)
    );

endmodule

// File: tb/soft_sphere_energy_check_test.sv
// Self-checking testbench for the soft-sphere energy check block
`timescale 1ns / 100ps

module soft_sphere_energy_check_test;

    localparam int unsigned STORE_DEPTH = sse_pkg::MAX_PARTICLES_DEF;
    localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
    localparam int N_DIRECTED = 18;

    typedef struct {
        logic [47:0] kin;
        logic [47:0] pot;
        logic [47:0] tot;
    } t_energy;

    typedef struct {
        logic [31:0] px, py, pz, vx, vy, vz, dia;
        logic        last;
        bit          typed;
        logic [47:0] kin, pot, tot;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [sse_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [sse_pkg::DATA_W-1:0] i_cfg_wdata = '0;

    sse_in_if  in_ch ();
    sse_out_if out_ch ();

    soft_sphere_energy_check u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [63:0] box_l, scale, strength;
    logic [31:0] store_x [STORE_DEPTH];
    logic [31:0] store_y [STORE_DEPTH];
    logic [31:0] store_z [STORE_DEPTH];
    logic [31:0] store_d [STORE_DEPTH];
    int unsigned stored_cnt;
    logic [63:0] kin_acc, pot_acc;

    t_energy expected_energies [$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned items_sent = 0;
    int unsigned overlap_sets = 0;
    bit          no_idle = 1'b0;

    function automatic logic [63:0] sat_sum48(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > {16'd0, SAT48}) ? {16'd0, SAT48} : s;
    endfunction

    function automatic logic [63:0] speed_sq(logic [31:0] v);
        logic [31:0] mag;
        mag = v[31] ? -v : v;
        return {32'd0, mag} * {32'd0, mag};
    endfunction

    function automatic logic [63:0] image_dist(logic [31:0] p, logic [31:0] q);
        logic [63:0] a, w, m;
        a = (p > q) ? 64'(p - q) : 64'(q - p);
        if (a <= box_l) begin
            w = box_l - a;
            m = (w < a) ? w : a;
        end else begin
            m = a - box_l;
        end
        return (m > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : m;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] r, t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic logic [63:0] overlap_energy(int unsigned k, logic [31:0] x,
                                                   logic [31:0] y, logic [31:0] z,
                                                   logic [31:0] dia);
        logic [63:0] mx, my, mz, d, dsum, cap, f, sq;
        logic [127:0] num;
        mx = image_dist(store_x[k], x);
        my = image_dist(store_y[k], y);
        mz = image_dist(store_z[k], z);
        d = root_floor(mx * mx + my * my + mz * mz);
        dsum = 64'(store_d[k]) + 64'(dia);
        cap = ((scale * {32'd0, dsum[31:0]}) >> 17) + (dsum[32] ? (scale << 15) : 64'd0);
        if (!(d < cap)) return 64'd0;
        num = 128'(cap - d) << 30;
        f = 64'(num / 128'(cap));
        sq = (f * f) >> 30;
        return (strength * sq) >> 23;
    endfunction

    // Advance the predictor by one particle; returns 1 when a result is due
    function automatic bit predict_particle(t_row r, output t_energy e);
        logic [63:0] v2, pe;
        v2 = speed_sq(r.vx) + speed_sq(r.vy) + speed_sq(r.vz);
        kin_acc = sat_sum48(kin_acc, v2 >> 9);
        for (int unsigned k = 0; k < stored_cnt; k++) begin
            pe = overlap_energy(k, r.px, r.py, r.pz, r.dia);
            pot_acc = sat_sum48(pot_acc, pe);
        end
        if (stored_cnt < STORE_DEPTH) begin
            store_x[stored_cnt] = r.px;
            store_y[stored_cnt] = r.py;
            store_z[stored_cnt] = r.pz;
            store_d[stored_cnt] = r.dia;
            stored_cnt++;
        end
        if (!r.last) return 1'b0;
        e.kin = kin_acc[47:0];
        e.pot = pot_acc[47:0];
        e.tot = 48'(sat_sum48(kin_acc, pot_acc));
        if (pot_acc != 0) overlap_sets++;
        stored_cnt = 0;
        kin_acc = 0;
        pot_acc = 0;
        return 1'b1;
    endfunction

    task automatic write_reg(sse_pkg::t_cfg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            sse_pkg::CFG_BOX_LENGTH:    box_l = {32'd0, value};
            sse_pkg::CFG_SIZE_SCALE:    scale = {32'd0, value};
            sse_pkg::CFG_PAIR_STRENGTH: strength = {32'd0, value};
            default: ;
        endcase
    endtask

    task automatic send_particle(t_row r);
        t_energy e;
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        in_ch.valid         <= 1'b1;
        in_ch.pos_x         <= r.px;
        in_ch.pos_y         <= r.py;
        in_ch.pos_z         <= r.pz;
        in_ch.vel_x         <= r.vx;
        in_ch.vel_y         <= r.vy;
        in_ch.vel_z         <= r.vz;
        in_ch.diameter      <= r.dia;
        in_ch.last_particle <= r.last;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        items_sent++;
        if (predict_particle(r, e)) begin
            if (r.typed) begin
                e.kin = r.kin;
                e.pot = r.pot;
                e.tot = r.tot;
            end
            expected_energies.push_back(e);
        end
        // drop valid once the transaction is taken
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_energies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_pos(logic [31:0] span);
        return ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, span);
    endfunction

    function automatic logic [31:0] rand_vel();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endfunction

    function automatic logic [31:0] rand_dia();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom;
            default: return $urandom_range(0, 32'h0002_0000);
        endcase
    endfunction

    // Random sets of small size, positions packed so pairs often overlap
    task automatic run_sets(int n_items, logic [31:0] span);
        t_row r;
        int left, set_len;
        left = n_items;
        while (left > 0) begin
            set_len = $urandom_range(1, 8);
            if (set_len > left) set_len = left;
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < set_len; i++) begin
                r = '{px: rand_pos(span), py: rand_pos(span), pz: rand_pos(span),
                      vx: rand_vel(), vy: rand_vel(), vz: rand_vel(), dia: rand_dia(),
                      last: (i == set_len - 1), typed: 1'b0,
                      kin: '0, pot: '0, tot: '0};
                send_particle(r);
            end
            left -= set_len;
        end
        no_idle = 1'b0;
    endtask

    t_row directed [N_DIRECTED];

    initial begin
        t_row r;
        directed = '{
            // empty kinematics
            '{0, 0, 0, 0, 0, 0, 0, 1, 1, 48'd0, 48'd0, 48'd0},
            // unit speed gives half in Q24.24
            '{0, 0, 0, 32'h0001_0000, 0, 0, 0, 1, 1, 48'h80_0000, 48'd0, 48'h80_0000},
            // most negative velocity saturates the kinetic sum
            '{0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1, 1,
              SAT48, 48'd0, SAT48},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 0},
            // coincident unit spheres: full overlap, half strength
            '{0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0, 0, 0, 32'h0001_0000, 1, 1, 48'd0, 48'h80_0000, 48'h80_0000},
            // zero pair size never overlaps
            '{32'h100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{32'h100, 0, 0, 0, 0, 0, 0, 1, 1, 48'd0, 48'd0, 48'd0},
            // wrap across the box edge
            '{0, 0, 0, 32'hFFFF_0000, 0, 0, 32'h0000_8000, 0, 0, 0, 0, 0},
            '{32'h0000_FFFF, 32'h0000_C000, 0, 0, 32'h0000_4000, 0, 32'h0000_8000, 1,
              0, 0, 0, 0},
            // outside the box, axis distance saturates
            '{32'hFFFF_FFFF, 0, 32'h8000_0000, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 0,
              0, 0, 0, 0},
            '{0, 32'hFFFF_FFFF, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
            '{32'h0000_2000, 32'h0000_1000, 32'h0000_3000, 32'h0000_0001, 32'hFFFF_FFFF,
              0, 32'h0001_8000, 1, 0, 0, 0, 0},
            // three close particles, partial overlaps
            '{32'h0000_1000, 32'h0000_1000, 32'h0000_1000, 32'h0003_0000, 0, 0,
              32'h0000_4000, 0, 0, 0, 0, 0},
            '{32'h0000_2000, 32'h0000_1000, 32'h0000_1000, 0, 32'hFFFD_0000, 0,
              32'h0000_4000, 0, 0, 0, 0, 0},
            '{32'h0000_1000, 32'h0000_3000, 32'h0000_1800, 0, 0, 32'h0000_0100,
              32'h0000_4000, 1, 0, 0, 0, 0},
            '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
              32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 0, 0},
            '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h5555_5555, 32'hAAAA_AAAA, 1, 0, 0, 0, 0}
        };

        box_l = 64'(sse_pkg::BOX_LENGTH_RST);
        scale = 64'(sse_pkg::SIZE_SCALE_RST);
        strength = 64'(sse_pkg::PAIR_STRENGTH_RST);
        stored_cnt = 0;
        kin_acc = 0;
        pot_acc = 0;

        in_ch.valid = 1'b0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
        in_ch.vel_x = '0;
        in_ch.vel_y = '0;
        in_ch.vel_z = '0;
        in_ch.diameter = '0;
        in_ch.last_particle = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_particle(directed[i]);
        wait_drained();

        // Fill the store past its depth; zero sizes keep the pair loop short
        write_reg(sse_pkg::CFG_BOX_LENGTH, 32'h0010_0000);
        for (int i = 0; i < STORE_DEPTH + 2; i++) begin
            r = '{px: $urandom, py: $urandom, pz: $urandom, vx: rand_vel(),
                  vy: rand_vel(), vz: rand_vel(), dia: 32'd0,
                  last: (i == STORE_DEPTH + 1), typed: 1'b0, kin: '0, pot: '0, tot: '0};
            if (i >= STORE_DEPTH - 2) r.dia = $urandom_range(0, 32'h0008_0000);
            send_particle(r);
        end
        wait_drained();

        write_reg(sse_pkg::CFG_SIZE_SCALE, 32'h0002_0000);
        write_reg(sse_pkg::CFG_PAIR_STRENGTH, 32'h0003_8000);
        run_sets(250, 32'h0004_0000);
        wait_drained();

        write_reg(sse_pkg::CFG_BOX_LENGTH, 32'd0);
        write_reg(sse_pkg::CFG_SIZE_SCALE, 32'd0);
        write_reg(sse_pkg::CFG_PAIR_STRENGTH, 32'd0);
        run_sets(150, 32'h0002_0000);
        wait_drained();

        write_reg(sse_pkg::CFG_BOX_LENGTH, 32'hFFFF_FFFF);
        write_reg(sse_pkg::CFG_SIZE_SCALE, 32'hFFFF_FFFF);
        write_reg(sse_pkg::CFG_PAIR_STRENGTH, 32'hFFFF_FFFF);
        run_sets(250, 32'h0004_0000);
        wait_drained();

        write_reg(sse_pkg::CFG_BOX_LENGTH, $urandom_range(32'h0000_8000, 32'h0008_0000));
        write_reg(sse_pkg::CFG_SIZE_SCALE, $urandom_range(32'h0000_4000, 32'h0004_0000));
        write_reg(sse_pkg::CFG_PAIR_STRENGTH, $urandom);
        run_sets(300, 32'h0008_0000);

        while (expected_energies.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Sent %0d particles, checked %0d energy results (%0d with overlap).",
                 items_sent, results_seen, overlap_sets);
        $display("Covered default, zero, maximum and random box/scale/strength and a full store.");
        if (mismatches == 0 && expected_energies.size() == 0) begin
            $display("soft_sphere_energy_check verification clean");
        end else begin
            $display("soft_sphere_energy_check verification failed");
        end
        $finish;
    end

    // Result side: random stalls, check each transaction against the oldest expectation
    initial begin
        t_energy e;
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            stall = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready && i_rst_n));
            results_seen++;
            if (expected_energies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result kin=%h pot=%h tot=%h",
                             out_ch.kinetic_energy, out_ch.potential_energy,
                             out_ch.total_energy);
            end else begin
                e = expected_energies.pop_front();
                if (out_ch.kinetic_energy !== e.kin || out_ch.potential_energy !== e.pot ||
                    out_ch.total_energy !== e.tot) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d exp kin=%h pot=%h tot=%h got %h %h %h",
                                 results_seen, e.kin, e.pot, e.tot, out_ch.kinetic_energy,
                                 out_ch.potential_energy, out_ch.total_energy);
                end
            end
        end
    end

    initial begin
        #200_000_000;
        $display("soft_sphere_energy_check verification failed");
        $finish;
    end

endmodule
